FILE: rtl/core/c6502_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c6502_pkg
// Operation codes, status bit positions and reset constants for the 6502
// execute unit.
// ----------------------------------------------------------------------------
package c6502_pkg;

    typedef enum logic [6:0] {
        OP_LDA = 7'd0, OP_LDX, OP_LDY, OP_STA, OP_STX, OP_STY, OP_ADC, OP_SBC,
        OP_AND, OP_ORA, OP_EOR, OP_CMP, OP_CPX, OP_CPY, OP_BIT, OP_INC, OP_DEC,
        OP_INX, OP_INY, OP_DEX, OP_DEY, OP_ASL_M, OP_LSR_M, OP_ROL_M, OP_ROR_M,
        OP_ASL_A, OP_LSR_A, OP_ROL_A, OP_ROR_A, OP_CLC, OP_SEC, OP_CLI, OP_SEI,
        OP_CLV, OP_CLD, OP_SED, OP_BPL, OP_BMI, OP_BVC, OP_BVS, OP_BCC, OP_BCS,
        OP_BNE, OP_BEQ, OP_TAX, OP_TXA, OP_TAY, OP_TYA, OP_TSX, OP_TXS, OP_PHA,
        OP_PHP, OP_PLA, OP_PLP, OP_NOP, OP_SLO, OP_RLA, OP_SRE, OP_RRA, OP_SAX,
        OP_LAX, OP_DCP, OP_ISB, OP_ANC, OP_ASR, OP_ARR, OP_XAA, OP_AXS, OP_AHX,
        OP_SHY, OP_SHX, OP_TAS, OP_LAS
    } t_op;

    // status byte: N V R B D I Z C
    localparam int FLAG_C = 0;
    localparam int FLAG_Z = 1;
    localparam int FLAG_I = 2;
    localparam int FLAG_D = 3;
    localparam int FLAG_B = 4;
    localparam int FLAG_R = 5;
    localparam int FLAG_V = 6;
    localparam int FLAG_N = 7;

    localparam logic [7:0] XAA_MAGIC = 8'hEE;
    localparam logic [7:0] SP_RESET  = 8'hFD;
    localparam logic [7:0] P_RESET   = 8'h24;

endpackage

FILE: rtl/core/c6502_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c6502 request / result channels
// Valid/ready channels carrying one decoded operation in and one result out.
// ----------------------------------------------------------------------------
interface c6502_req_if;
    logic       valid;
    logic       ready;
    logic [6:0] kind;
    logic [7:0] operand;
    logic [7:0] addr_high;

    modport source (output valid, output kind, output operand, output addr_high,
                    input ready);
    modport sink   (input valid, input kind, input operand, input addr_high,
                    output ready);
endinterface

interface c6502_rsp_if;
    logic       valid;
    logic       ready;
    logic       write_enable;
    logic [7:0] write_data;
    logic       branch_taken;
    logic [7:0] acc_out;
    logic [7:0] x_out;
    logic [7:0] y_out;
    logic [7:0] sp_out;
    logic [7:0] status_out;

    modport source (output valid, output write_enable, output write_data,
                    output branch_taken, output acc_out, output x_out,
                    output y_out, output sp_out, output status_out,
                    input ready);
    modport sink   (input valid, input write_enable, input write_data,
                    input branch_taken, input acc_out, input x_out,
                    input y_out, input sp_out, input status_out,
                    output ready);
endinterface

FILE: rtl/core/cpu_6502_execute_unit_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu_6502_execute_unit_core
// Executes one decoded 6502 operation (documented set plus the NES illegal
// opcodes) per request against the A, X, Y, SP and P registers.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake      payload
//  -------   ---  ---------      -------------------------------------------
//  i_req     in   valid/ready    kind[6:0], operand[7:0], addr_high[7:0]
//  o_rsp     out  valid/ready    write_enable, write_data, branch_taken,
//                                acc_out, x_out, y_out, sp_out, status_out
//
//  A request accepted into the request register passes the ALU into the
//  result register and the register file once the result stage is free.
//  One request per cycle sustained while o_rsp.ready stays high.
//  Reset (i_rst_n low, synchronous) empties both stages and loads
//  A=X=Y=0, SP=0xFD, P=0x24.
//  A stalled result holds both stages; i_req.ready then drops only if the
//  request register is also full.
//
module cpu_6502_execute_unit_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    c6502_req_if.sink          i_req,
    c6502_rsp_if.source        o_rsp
);
    import c6502_pkg::*;

    // request stage
    logic       r_req_valid;
    logic [6:0] r_kind;
    logic [7:0] r_operand;
    logic [7:0] r_addr_high;

    // result stage; the register file doubles as the register outputs since
    // it only moves when a new result is loaded
    logic       r_rsp_valid;
    logic       r_we;
    logic [7:0] r_wd;
    logic       r_br;
    logic [7:0] r_a, r_x, r_y, r_sp, r_p;

    logic [7:0] n_a, n_x, n_y, n_sp, n_p, n_wd;
    logic       n_we, n_br;

    logic       advance;    // result stage free to take a new value
    logic       exec;       // request stage executes this cycle

    assign advance     = !r_rsp_valid || o_rsp.ready;
    assign exec        = r_req_valid && advance;
    assign i_req.ready = !r_req_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_req_valid <= i_req.valid;
        end
        if (i_req.ready && i_req.valid) begin
            r_kind      <= i_req.kind;
            r_operand   <= i_req.operand;
            r_addr_high <= i_req.addr_high;
        end
    end

    // ------------------------------------------------------------------
    // ALU datapath: one shared adder for ADC/SBC/RRA/ISB, one subtractor
    // for the compares, DCP and AXS.
    // ------------------------------------------------------------------
    function automatic logic [7:0] set_nz(input logic [7:0] p, input logic [7:0] v);
        logic [7:0] q;
        q         = p;
        q[FLAG_N] = v[7];
        q[FLAG_Z] = (v == 8'h00);
        return q;
    endfunction

    t_op        op;
    logic [7:0] m;
    logic       c;
    logic [7:0] hi1, m_inc, m_dec;
    logic [7:0] asl_m, lsr_m, rol_m, ror_m;
    logic [7:0] add_in;
    logic       add_cin;
    logic [8:0] add_sum;
    logic       add_v;
    logic [7:0] cmp_reg, cmp_val;
    logic [8:0] cmp_diff;
    logic [7:0] a_and_m, a_and_x, arr_res;

    always_comb begin
        op      = t_op'(r_kind);
        m       = r_operand;
        c       = r_p[FLAG_C];
        hi1     = r_addr_high + 8'd1;
        m_inc   = m + 8'd1;
        m_dec   = m - 8'd1;
        asl_m   = {m[6:0], 1'b0};
        rol_m   = {m[6:0], c};
        lsr_m   = {1'b0, m[7:1]};
        ror_m   = {c, m[7:1]};
        a_and_m = r_a & m;
        a_and_x = r_a & r_x;
        arr_res = {c, a_and_m[7:1]};

        case (op)
            OP_SBC:  add_in = ~m;
            OP_RRA:  add_in = ror_m;
            OP_ISB:  add_in = ~m_inc;
            default: add_in = m;
        endcase
        // RRA adds with the carry its rotate just produced
        add_cin = (op == OP_RRA) ? m[0] : c;
        add_sum = {1'b0, r_a} + {1'b0, add_in} + {8'h00, add_cin};
        add_v   = (~(r_a[7] ^ add_in[7])) & (r_a[7] ^ add_sum[7]);

        case (op)
            OP_CPX:  cmp_reg = r_x;
            OP_CPY:  cmp_reg = r_y;
            OP_AXS:  cmp_reg = a_and_x;
            default: cmp_reg = r_a;
        endcase
        cmp_val  = (op == OP_DCP) ? m_dec : m;
        cmp_diff = {1'b0, cmp_reg} - {1'b0, cmp_val};
    end

    always_comb begin
        n_a  = r_a;
        n_x  = r_x;
        n_y  = r_y;
        n_sp = r_sp;
        n_p  = r_p;
        n_we = 1'b0;
        n_wd = 8'h00;
        n_br = 1'b0;

        unique case (op)
            OP_LDA: begin n_a = m; n_p = set_nz(r_p, m); end
            OP_LDX: begin n_x = m; n_p = set_nz(r_p, m); end
            OP_LDY: begin n_y = m; n_p = set_nz(r_p, m); end
            OP_STA: begin n_we = 1'b1; n_wd = r_a; end
            OP_STX: begin n_we = 1'b1; n_wd = r_x; end
            OP_STY: begin n_we = 1'b1; n_wd = r_y; end
            OP_ADC, OP_SBC, OP_RRA, OP_ISB: begin
                n_a         = add_sum[7:0];
                n_p         = set_nz(r_p, add_sum[7:0]);
                n_p[FLAG_C] = add_sum[8];
                n_p[FLAG_V] = add_v;
                if (op == OP_RRA) begin
                    n_we = 1'b1;
                    n_wd = ror_m;
                end else if (op == OP_ISB) begin
                    n_we = 1'b1;
                    n_wd = m_inc;
                end
            end
            OP_AND: begin n_a = a_and_m; n_p = set_nz(r_p, a_and_m); end
            OP_ORA: begin n_a = r_a | m; n_p = set_nz(r_p, r_a | m); end
            OP_EOR: begin n_a = r_a ^ m; n_p = set_nz(r_p, r_a ^ m); end
            OP_CMP, OP_CPX, OP_CPY, OP_DCP: begin
                n_p         = set_nz(r_p, cmp_diff[7:0]);
                n_p[FLAG_C] = !cmp_diff[8];
                if (op == OP_DCP) begin
                    n_we = 1'b1;
                    n_wd = m_dec;
                end
            end
            OP_AXS: begin
                n_x         = cmp_diff[7:0];
                n_p         = set_nz(r_p, cmp_diff[7:0]);
                n_p[FLAG_C] = !cmp_diff[8];
            end
            OP_BIT: begin
                n_p[FLAG_V] = m[6];
                n_p[FLAG_N] = m[7];
                n_p[FLAG_Z] = (a_and_m == 8'h00);
            end
            OP_INC: begin n_we = 1'b1; n_wd = m_inc; n_p = set_nz(r_p, m_inc); end
            OP_DEC: begin n_we = 1'b1; n_wd = m_dec; n_p = set_nz(r_p, m_dec); end
            OP_INX: begin n_x = r_x + 8'd1; n_p = set_nz(r_p, r_x + 8'd1); end
            OP_INY: begin n_y = r_y + 8'd1; n_p = set_nz(r_p, r_y + 8'd1); end
            OP_DEX: begin n_x = r_x - 8'd1; n_p = set_nz(r_p, r_x - 8'd1); end
            OP_DEY: begin n_y = r_y - 8'd1; n_p = set_nz(r_p, r_y - 8'd1); end
            OP_ASL_M: begin
                n_we = 1'b1; n_wd = asl_m;
                n_p = set_nz(r_p, asl_m); n_p[FLAG_C] = m[7];
            end
            OP_LSR_M: begin
                n_we = 1'b1; n_wd = lsr_m;
                n_p = set_nz(r_p, lsr_m); n_p[FLAG_C] = m[0];
            end
            OP_ROL_M: begin
                n_we = 1'b1; n_wd = rol_m;
                n_p = set_nz(r_p, rol_m); n_p[FLAG_C] = m[7];
            end
            OP_ROR_M: begin
                n_we = 1'b1; n_wd = ror_m;
                n_p = set_nz(r_p, ror_m); n_p[FLAG_C] = m[0];
            end
            OP_ASL_A: begin
                n_a = {r_a[6:0], 1'b0};
                n_p = set_nz(r_p, {r_a[6:0], 1'b0}); n_p[FLAG_C] = r_a[7];
            end
            OP_LSR_A: begin
                n_a = {1'b0, r_a[7:1]};
                n_p = set_nz(r_p, {1'b0, r_a[7:1]}); n_p[FLAG_C] = r_a[0];
            end
            OP_ROL_A: begin
                n_a = {r_a[6:0], c};
                n_p = set_nz(r_p, {r_a[6:0], c}); n_p[FLAG_C] = r_a[7];
            end
            OP_ROR_A: begin
                n_a = {c, r_a[7:1]};
                n_p = set_nz(r_p, {c, r_a[7:1]}); n_p[FLAG_C] = r_a[0];
            end
            OP_CLC: n_p[FLAG_C] = 1'b0;
            OP_SEC: n_p[FLAG_C] = 1'b1;
            OP_CLI: n_p[FLAG_I] = 1'b0;
            OP_SEI: n_p[FLAG_I] = 1'b1;
            OP_CLV: n_p[FLAG_V] = 1'b0;
            OP_CLD: n_p[FLAG_D] = 1'b0;
            OP_SED: n_p[FLAG_D] = 1'b1;
            OP_BPL: n_br = !r_p[FLAG_N];
            OP_BMI: n_br = r_p[FLAG_N];
            OP_BVC: n_br = !r_p[FLAG_V];
            OP_BVS: n_br = r_p[FLAG_V];
            OP_BCC: n_br = !r_p[FLAG_C];
            OP_BCS: n_br = r_p[FLAG_C];
            OP_BNE: n_br = !r_p[FLAG_Z];
            OP_BEQ: n_br = r_p[FLAG_Z];
            OP_TAX: begin n_x = r_a;  n_p = set_nz(r_p, r_a); end
            OP_TXA: begin n_a = r_x;  n_p = set_nz(r_p, r_x); end
            OP_TAY: begin n_y = r_a;  n_p = set_nz(r_p, r_a); end
            OP_TYA: begin n_a = r_y;  n_p = set_nz(r_p, r_y); end
            OP_TSX: begin n_x = r_sp; n_p = set_nz(r_p, r_sp); end
            OP_TXS: n_sp = r_x;
            OP_PHA: begin n_we = 1'b1; n_wd = r_a; n_sp = r_sp - 8'd1; end
            OP_PHP: begin
                n_we = 1'b1;
                n_wd = r_p;
                n_wd[FLAG_B] = 1'b1;
                n_wd[FLAG_R] = 1'b1;
                n_sp = r_sp - 8'd1;
            end
            OP_PLA: begin n_sp = r_sp + 8'd1; n_a = m; n_p = set_nz(r_p, m); end
            OP_PLP: begin
                n_sp = r_sp + 8'd1;
                n_p = m;
                n_p[FLAG_B] = 1'b0;
                n_p[FLAG_R] = 1'b1;
            end
            OP_NOP: ;
            OP_SLO: begin
                n_we = 1'b1; n_wd = asl_m;
                n_a = r_a | asl_m;
                n_p = set_nz(r_p, r_a | asl_m); n_p[FLAG_C] = m[7];
            end
            OP_RLA: begin
                n_we = 1'b1; n_wd = rol_m;
                n_a = r_a & rol_m;
                n_p = set_nz(r_p, r_a & rol_m); n_p[FLAG_C] = m[7];
            end
            OP_SRE: begin
                n_we = 1'b1; n_wd = lsr_m;
                n_a = r_a ^ lsr_m;
                n_p = set_nz(r_p, r_a ^ lsr_m); n_p[FLAG_C] = m[0];
            end
            OP_SAX: begin n_we = 1'b1; n_wd = a_and_x; end
            OP_LAX: begin n_a = m; n_x = m; n_p = set_nz(r_p, m); end
            OP_ANC: begin
                n_a = a_and_m;
                n_p = set_nz(r_p, a_and_m); n_p[FLAG_C] = a_and_m[7];
            end
            OP_ASR: begin
                n_a = {1'b0, a_and_m[7:1]};
                n_p = set_nz(r_p, {1'b0, a_and_m[7:1]}); n_p[FLAG_C] = a_and_m[0];
            end
            OP_ARR: begin
                n_a = arr_res;
                n_p = set_nz(r_p, arr_res);
                n_p[FLAG_C] = arr_res[6];
                n_p[FLAG_V] = arr_res[6] ^ arr_res[5];
            end
            OP_XAA: begin
                n_a = (r_a | XAA_MAGIC) & r_x & m;
                n_p = set_nz(r_p, (r_a | XAA_MAGIC) & r_x & m);
            end
            // unstable stores: value gated by the address high byte plus one
            OP_AHX: begin n_we = 1'b1; n_wd = a_and_x & hi1; end
            OP_SHY: begin n_we = 1'b1; n_wd = r_y & hi1; end
            OP_SHX: begin n_we = 1'b1; n_wd = r_x & hi1; end
            OP_TAS: begin n_sp = a_and_x; n_we = 1'b1; n_wd = a_and_x & hi1; end
            OP_LAS: begin
                n_a  = m & r_sp;
                n_x  = m & r_sp;
                n_sp = m & r_sp;
                n_p  = set_nz(r_p, m & r_sp);
            end
            default: ;  // undefined kinds leave everything unchanged
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
            r_a         <= 8'h00;
            r_x         <= 8'h00;
            r_y         <= 8'h00;
            r_sp        <= SP_RESET;
            r_p         <= P_RESET;
        end else begin
            if (advance) begin
                r_rsp_valid <= r_req_valid;
            end
            if (exec) begin
                r_a  <= n_a;
                r_x  <= n_x;
                r_y  <= n_y;
                r_sp <= n_sp;
                r_p  <= n_p;
            end
        end
        if (exec) begin
            r_we <= n_we;
            r_wd <= n_wd;
            r_br <= n_br;
        end
    end

    assign o_rsp.valid        = r_rsp_valid;
    assign o_rsp.write_enable = r_we;
    assign o_rsp.write_data   = r_wd;
    assign o_rsp.branch_taken = r_br;
    assign o_rsp.acc_out      = r_a;
    assign o_rsp.x_out        = r_x;
    assign o_rsp.y_out        = r_y;
    assign o_rsp.sp_out       = r_sp;
    assign o_rsp.status_out   = r_p;

endmodule
